/* hdl/hntx_pkg.sv */
`timescale 1ns / 1ps
// Package for the HDLC NRZI bit transmitter: command codes, queue item type,
// line constants and the CRC-16 bit step. No dependencies.
package hntx_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_FLAG  = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_FCS   = 2'd3
   } cmd_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned LEFT_W      = 5;

   localparam logic [15:0]       CRC_POLY  = 16'h8408;
   localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
   localparam logic [7:0]        FLAG_BYTE = 8'h7E;
   localparam logic [7:0]        BYTE_MASK = 8'hFF;
   localparam logic [LEFT_W-1:0] BYTE_BITS = 5'd8;
   localparam logic [LEFT_W-1:0] FCS_BITS  = 5'd16;
   localparam logic [2:0]        RUN_MAX   = 3'd7;
   localparam logic [2:0]        STUFF_RUN = 3'd5;

   // Classified command as it waits in the queue
   typedef struct packed {
      logic       is_start;
      logic       is_fcs;
      logic       upd_crc;
      logic       do_stuff;
      logic [7:0] bits;
   } item_type;

   // Reflected CRC-16, one bit
   function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic b);
      logic [15:0] c;
      c = {crc[15:1], crc[0] ^ b};
      if (c[0]) begin
         crc_bit = (c >> 1) ^ CRC_POLY;
      end else begin
         crc_bit = c >> 1;
      end
   endfunction

endpackage

/* hdl/hntx_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and line-bit channels.
// Depends on nothing.
interface hntx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface hntx_rsp_if;
   logic valid;
   logic ready;
   logic tone;
   logic stuffed;
   logic last;

   modport source (output valid, output tone, output stuffed, output last, input ready);
   modport sink   (input valid, input tone, input stuffed, input last, output ready);
endinterface

/* hdl/hdlc_nrzi_bit_transmitter_unit.sv */
`timescale 1ns / 1ps
// HDLC NRZI bit transmitter. An accepted command goes into a queue slot and its first
// line bit is then computed by the back end and held in the output register.
// Throughput: one line bit per cycle while the receiver is ready, set by the serialiser;
// commands follow one another with no gap between them.
// Reset (synchronous): CRC 0xFFFF, ones run 0, tone 0, queue and output register empty.
// Depends on hntx_pkg, hntx_if, hntx_front, hntx_queue and hntx_back.
module hdlc_nrzi_bit_transmitter_unit #(
   parameter int unsigned QUEUE_DEPTH = hntx_pkg::QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   hntx_req_if.sink   req_chan,
   hntx_rsp_if.source rsp_chan
);

   // Handshake between front end and queue
   logic               push;
   logic               push_ready;
   hntx_pkg::item_type push_item;

   // Handshake between queue and back end
   logic               pop;
   logic               head_valid;
   hntx_pkg::item_type head_item;

   // Accept commands whenever the queue has room and classify them
   hntx_front u_front (
      .req_chan   (req_chan),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Hold classified commands so the front end keeps accepting while bits go out
   hntx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Serialise: one bit per cycle unless stalled, insert stuff zeros, track CRC and tone;
   // the next command is picked up in the same cycle as the previous one's last bit drains
   hntx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* hdl/hntx_front.sv */
`timescale 1ns / 1ps
// Front end: accepts commands and classifies them into queue items.
// Depends on hntx_pkg and hntx_req_if.
module hntx_front (
   hntx_req_if.sink            req_chan,
   output logic                push,
   output hntx_pkg::item_type  push_item,
   input  logic                push_ready
);

   always_comb begin
      req_chan.ready     = push_ready;
      push               = req_chan.valid && push_ready;
      push_item.is_start = 1'b0;
      push_item.is_fcs   = 1'b0;
      push_item.upd_crc  = 1'b0;
      push_item.do_stuff = 1'b0;
      push_item.bits     = req_chan.data_byte;
      case (hntx_pkg::cmd_type'(req_chan.command))
         hntx_pkg::CMD_START: begin
            push_item.is_start = 1'b1;
         end
         hntx_pkg::CMD_FLAG: begin
            push_item.bits = hntx_pkg::FLAG_BYTE;
         end
         hntx_pkg::CMD_DATA: begin
            push_item.upd_crc  = 1'b1;
            push_item.do_stuff = 1'b1;
         end
         hntx_pkg::CMD_FCS: begin
            push_item.is_fcs   = 1'b1;
            push_item.do_stuff = 1'b1;
         end
         default: begin
            push_item.is_start = 1'b0;
         end
      endcase
   end

endmodule

/* hdl/hntx_queue.sv */
`timescale 1ns / 1ps
// Short FIFO of classified items between front and back end.
// Depends on hntx_pkg.
module hntx_queue #(
   parameter int unsigned DEPTH = hntx_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hntx_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output logic               head_valid,
   output hntx_pkg::item_type head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   hntx_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/hntx_back.sv */
`timescale 1ns / 1ps
// Back end: serialises queue items into NRZI line bits with stuffing and CRC.
// Depends on hntx_pkg and hntx_rsp_if.
module hntx_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  hntx_pkg::item_type head_item,
   output logic               pop,
   hntx_rsp_if.source         rsp_chan
);

   localparam int unsigned LW = hntx_pkg::LEFT_W;

   logic [15:0]   crc_ff, crc_in;
   logic [2:0]    ones_ff, ones_in;
   logic          tone_ff, tone_in;
   logic          busy_ff, busy_in;
   logic          pend_ff, pend_in;
   logic [15:0]   bits_ff, bits_in;
   logic [LW-1:0] left_ff, left_in;
   logic          upd_ff, upd_in;
   logic          stuff_ff, stuff_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_tone_ff, rsp_tone_in;
   logic rsp_stuffed_ff, rsp_stuffed_in;
   logic rsp_last_ff, rsp_last_in;

   logic          advance, load, step;
   logic [15:0]   w_bits;
   logic [LW-1:0] w_left, left_dec;
   logic          w_upd, w_stuff;
   logic [2:0]    ones_inc;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.tone    = rsp_tone_ff;
   assign rsp_chan.stuffed = rsp_stuffed_ff;
   assign rsp_chan.last    = rsp_last_ff;

   always_comb begin
      advance = !rsp_valid_ff || rsp_chan.ready;
      load    = !busy_ff && !pend_ff && head_valid;
      step    = advance && (pend_ff || busy_ff || head_valid);
      pop     = advance && load;

      if (busy_ff) begin
         w_bits  = bits_ff;
         w_left  = left_ff;
         w_upd   = upd_ff;
         w_stuff = stuff_ff;
      end else begin
         w_bits  = head_item.is_fcs ? {~crc_ff[15:8], ~crc_ff[7:0]}
                                    : {8'h00, head_item.bits};
         w_left  = head_item.is_fcs ? hntx_pkg::FCS_BITS : hntx_pkg::BYTE_BITS;
         w_upd   = head_item.upd_crc;
         w_stuff = head_item.do_stuff;
      end
      left_dec = w_left - 1'b1;
      ones_inc = (ones_ff == hntx_pkg::RUN_MAX) ? ones_ff : ones_ff + 1'b1;

      crc_in   = crc_ff;
      ones_in  = ones_ff;
      tone_in  = tone_ff;
      busy_in  = busy_ff;
      pend_in  = pend_ff;
      bits_in  = bits_ff;
      left_in  = left_ff;
      upd_in   = upd_ff;
      stuff_in = stuff_ff;

      rsp_valid_in   = advance ? step : rsp_valid_ff;
      rsp_tone_in    = rsp_tone_ff;
      rsp_stuffed_in = rsp_stuffed_ff;
      rsp_last_in    = rsp_last_ff;

      if (step) begin
         if (pend_ff) begin
            tone_in        = !tone_ff;
            ones_in        = '0;
            pend_in        = 1'b0;
            busy_in        = (left_ff != '0);
            rsp_tone_in    = !tone_ff;
            rsp_stuffed_in = 1'b1;
            rsp_last_in    = (left_ff == '0);
         end else if (!busy_ff && head_item.is_start) begin
            crc_in         = hntx_pkg::CRC_INIT;
            ones_in        = '0;
            tone_in        = 1'b0;
            rsp_tone_in    = 1'b0;
            rsp_stuffed_in = 1'b0;
            rsp_last_in    = 1'b1;
         end else begin
            bits_in  = w_bits >> 1;
            left_in  = left_dec;
            upd_in   = w_upd;
            stuff_in = w_stuff;
            busy_in  = (left_dec != '0);
            if (w_upd) begin
               crc_in = hntx_pkg::crc_bit(crc_ff, w_bits[0]);
            end else if (load && head_item.is_fcs) begin
               crc_in = crc_ff >> 8;
            end
            rsp_stuffed_in = 1'b0;
            if (!w_bits[0]) begin
               tone_in     = !tone_ff;
               ones_in     = '0;
               rsp_tone_in = !tone_ff;
               rsp_last_in = (left_dec == '0);
            end else begin
               ones_in     = ones_inc;
               rsp_tone_in = tone_ff;
               if (w_stuff && ones_inc == hntx_pkg::STUFF_RUN) begin
                  pend_in     = 1'b1;
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_last_in = (left_dec == '0);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= hntx_pkg::CRC_INIT;
         ones_ff      <= '0;
         tone_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         ones_ff      <= ones_in;
         tone_ff      <= tone_in;
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff        <= bits_in;
      left_ff        <= left_in;
      upd_ff         <= upd_in;
      stuff_ff       <= stuff_in;
      rsp_tone_ff    <= rsp_tone_in;
      rsp_stuffed_ff <= rsp_stuffed_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule
